[rtl/kcs_pkg.sv]
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types, constants and tables of the keyframe camera sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kcs_pkg;

  localparam int KCS_MAX_KEYS  = 16;
  localparam int KCS_FRAC_BITS = 16;
  localparam int Q30           = 30;
  localparam logic [12:0] EASE_LINEAR = 13'd256;
  localparam logic [23:0] FOV_MAX     = 24'hFFFFFF;

  // lerp channels
  localparam logic [2:0] CH_PX  = 3'd0;
  localparam logic [2:0] CH_PY  = 3'd1;
  localparam logic [2:0] CH_PZ  = 3'd2;
  localparam logic [2:0] CH_TX  = 3'd3;
  localparam logic [2:0] CH_TY  = 3'd4;
  localparam logic [2:0] CH_TZ  = 3'd5;
  localparam logic [2:0] CH_FOV = 3'd6;

  typedef struct packed {
    logic signed [31:0] ktime;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [23:0]        fov;
    logic [12:0]        ease;
  } key_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_WRITE,
    OP_LOAD,
    OP_EMPTY,
    OP_IDX0,
    OP_PUT,
    OP_IDXL,
    OP_IDX1,
    OP_IDXINC,
    OP_LATB,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_POWINIT,
    OP_NORM,
    OP_LOG,
    OP_MULE,
    OP_EXPINIT,
    OP_EXP,
    OP_EXPFIN,
    OP_SQ_PW,
    OP_SQ_S,
    OP_SQ_F,
    OP_FIN,
    OP_LERP,
    OP_LFIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
    logic [2:0] chan;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic t_le;
    logic t_ge;
    logic pw_special;
    logic x_norm;
    logic pexp_zero;
  } sts_t;

  typedef logic [31:0][29:0] root_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] r;
    logic [63:0] bit_v;
    vv    = v;
    r     = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > vv) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (vv >= r + bit_v) begin
          vv = vv - (r + bit_v);
          r  = (r >> 1) + bit_v;
        end else begin
          r = r >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return r;
  endfunction

  // successive square roots of one half in Q30, entry k is the k-th root
  function automatic root_tab_t make_roots();
    root_tab_t   tab;
    logic [63:0] c;
    tab = '0;
    c   = 64'd1 << (Q30 - 1);
    for (int k = 1; k <= 30; k++) begin
      c      = isqrt64(c << Q30);
      tab[k] = c[29:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = make_roots();

endpackage

`default_nettype wire

[rtl/kcs_ctrl.sv]
// ----------------------------------------------------------------------------
// kcs_ctrl
// Sequencer: key search, division, power, smoothstep and lerp steps.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_ctrl #(
  parameter int FRAC_BITS = kcs_pkg::KCS_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          req_type,
  input  kcs_pkg::sts_t sts,
  output kcs_pkg::cmd_t cmd,
  output logic          busy
);
  import kcs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_RA0, S_T0, S_RAL, S_TL, S_RAS, S_TS, S_RAA, S_TA,
    S_DIV, S_POW, S_NORM, S_LOG, S_MULE, S_EXPI, S_EXP, S_EXPF,
    S_SQ1, S_FN1, S_SQ2, S_FN2, S_SQ3, S_FN3, S_LRP, S_LFN
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NOP;
    cmd.step   = cnt;
    cmd.chan   = cnt[2:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type) begin
            cmd.op     = OP_LOAD;
            state_next = S_CHK;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_CHK: begin
        if (sts.n_zero) begin
          cmd.op     = OP_EMPTY;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_IDX0;
          state_next = S_RA0;
        end
      end
      S_RA0: state_next = S_T0;
      S_T0: begin
        if (sts.n_one || sts.t_le) begin
          cmd.op     = OP_PUT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_IDXL;
          state_next = S_RAL;
        end
      end
      S_RAL: state_next = S_TL;
      S_TL: begin
        if (sts.t_ge) begin
          cmd.op     = OP_PUT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_IDX1;
          state_next = S_RAS;
        end
      end
      S_RAS: state_next = S_TS;
      S_TS: begin
        if (sts.t_le) begin
          cmd.op     = OP_LATB;
          state_next = S_RAA;
        end else begin
          cmd.op     = OP_IDXINC;
          state_next = S_RAS;
        end
      end
      S_RAA: state_next = S_TA;
      S_TA: begin
        cmd.op     = OP_DIVINIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIVSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(FRAC_BITS)) state_next = S_POW;
      end
      S_POW: begin
        cmd.op     = OP_POWINIT;
        state_next = sts.pw_special ? S_SQ1 : S_NORM;
      end
      S_NORM: begin
        if (sts.x_norm) begin
          cnt_next   = 5'd1;
          state_next = S_LOG;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_LOG: begin
        cmd.op   = OP_LOG;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(Q30)) state_next = S_MULE;
      end
      S_MULE: begin
        cmd.op     = OP_MULE;
        state_next = S_EXPI;
      end
      S_EXPI: begin
        cmd.op     = OP_EXPINIT;
        cnt_next   = 5'd1;
        state_next = sts.pexp_zero ? S_SQ1 : S_EXP;
      end
      S_EXP: begin
        cmd.op   = OP_EXP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(Q30)) state_next = S_EXPF;
      end
      S_EXPF: begin
        cmd.op     = OP_EXPFIN;
        state_next = S_SQ1;
      end
      S_SQ1: begin cmd.op = OP_SQ_PW; state_next = S_FN1; end
      S_FN1: begin cmd.op = OP_FIN;   state_next = S_SQ2; end
      S_SQ2: begin cmd.op = OP_SQ_S;  state_next = S_FN2; end
      S_FN2: begin cmd.op = OP_FIN;   state_next = S_SQ3; end
      S_SQ3: begin cmd.op = OP_SQ_F;  state_next = S_FN3; end
      S_FN3: begin
        cmd.op     = OP_FIN;
        cnt_next   = '0;
        state_next = S_LRP;
      end
      S_LRP: begin
        cmd.op   = OP_LERP;
        cnt_next = cnt + 5'd1;
        if (cnt[2:0] == CH_FOV) state_next = S_LFN;
      end
      S_LFN: begin
        cmd.op     = OP_LFIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

[rtl/kcs_dp.sv]
// ----------------------------------------------------------------------------
// kcs_dp
// Key store, divider, log/exp power unit, smoothstep unit and lerp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_dp #(
  parameter int MAX_KEYS  = kcs_pkg::KCS_MAX_KEYS,
  parameter int FRAC_BITS = kcs_pkg::KCS_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  kcs_pkg::cmd_t      cmd,
  output kcs_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic [3:0]         key_index,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tgt_x,
  input  logic signed [31:0] tgt_y,
  input  logic signed [31:0] tgt_z,
  input  logic [23:0]        key_fov,
  input  logic [12:0]        key_ease,
  input  logic signed [31:0] sample_time,
  output logic               done,
  output logic               track_empty,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_tgt_x,
  output logic signed [31:0] out_tgt_y,
  output logic signed [31:0] out_tgt_z,
  output logic [23:0]        out_fov
);
  import kcs_pkg::*;

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int FW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 36;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic [63:0] FOV75_W = 64'd75 << FRAC_BITS;
  localparam logic [23:0] FOV75 = (FOV75_W > 64'(FOV_MAX)) ? FOV_MAX : FOV75_W[23:0];

  key_t mem [MAX_KEYS];
  key_t rd_q, rec_a, rec_b;

  logic [4:0]         key_count;
  logic [IW-1:0]      idx;
  logic signed [31:0] t_q;
  logic [33:0]        rem;
  logic [32:0]        span;
  logic [FW-1:0]      fq;
  logic [12:0]        e_q;
  logic [31:0]        x_q;
  logic [4:0]         ip_q;
  logic [29:0]        fracq;
  logic [39:0]        pr;
  logic [30:0]        y_q;
  logic [FW-1:0]      pw, sx, sx2, sres, s2;
  logic signed [PW-1:0] lp;
  logic [2:0]         lch;
  logic               lv;

  // ---- key count and search status
  logic [NW-1:0] ncnt;
  logic [IW-1:0] last_idx;
  logic          slot_ok;

  assign ncnt = ({27'b0, key_count} > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign last_idx = IW'(ncnt - NW'(1));
  assign slot_ok = ({28'b0, key_index} < 32'(MAX_KEYS));

  // ---- divider
  logic signed [32:0] diff_w, span_w;
  logic               div_ge;

  assign diff_w = 33'(t_q) - 33'(rd_q.ktime);
  assign span_w = 33'(rec_b.ktime) - 33'(rd_q.ktime);
  assign div_ge = (rem >= {1'b0, span});

  // ---- power unit
  logic [63:0] sq;
  logic [34:0] neg;
  logic [47:0] prod_e;
  logic [9:0]  pi_w;
  logic [60:0] ymul;
  logic [30:0] ysh;
  logic [4:0]  bitsel;

  assign sq     = 64'(x_q) * 64'(x_q);
  assign neg    = {ip_q, 30'b0} - {5'b0, fracq};
  assign prod_e = 48'(neg) * 48'(e_q);
  assign pi_w   = pr[39:30];
  assign ymul   = 61'(y_q) * 61'(ROOTS[cmd.step]);
  assign ysh    = y_q >> (pi_w[4:0] + 5'(Q30 - FRAC_BITS));
  assign bitsel = 5'(Q30) - cmd.step;

  // ---- smoothstep unit
  logic [FW-1:0]   sm_src;
  logic [2*FW-1:0] sqs;
  logic [FW:0]     w3;
  logic [2*FW:0]   fprod;

  always_comb begin
    unique case (cmd.op)
      OP_SQ_PW: sm_src = pw;
      OP_SQ_S:  sm_src = sres;
      default:  sm_src = fq;
    endcase
  end

  assign sqs   = (2*FW)'(sm_src) * (2*FW)'(sm_src);
  assign w3    = ((FW+1)'(3) << FRAC_BITS) - {sx, 1'b0};
  assign fprod = (2*FW+1)'(sx2) * (2*FW+1)'(w3);

  // ---- lerp unit
  function automatic logic signed [33:0] pick(key_t k, logic [2:0] c);
    logic signed [33:0] v;
    unique case (c)
      CH_PX:   v = 34'(k.px);
      CH_PY:   v = 34'(k.py);
      CH_PZ:   v = 34'(k.pz);
      CH_TX:   v = 34'(k.tx);
      CH_TY:   v = 34'(k.ty);
      CH_TZ:   v = 34'(k.tz);
      default: v = {10'b0, k.fov};
    endcase
    return v;
  endfunction

  logic signed [33:0]   la, lb, ld;
  logic signed [FW:0]   ls;
  logic signed [PW-1:0] lprod, fa, fr, lo_v, hi_v, fc;
  logic [31:0]          res32;

  assign la    = pick(rec_a, cmd.chan);
  assign lb    = pick(rec_b, cmd.chan);
  assign ld    = lb - la;
  assign ls    = (cmd.chan == CH_FOV) ? {1'b0, sres} : {1'b0, s2};
  assign lprod = PW'(ld) * PW'(ls);

  assign fa   = PW'(pick(rec_a, lch));
  assign fr   = fa + (lp >>> FRAC_BITS);
  assign lo_v = (lch == CH_FOV) ? PW'(0) : -(PW'(64'sh8000_0000));
  assign hi_v = (lch == CH_FOV) ? PW'({1'b0, FOV_MAX}) : PW'(33'sh0_7FFF_FFFF);

  always_comb begin
    if (fr < lo_v)      fc = lo_v;
    else if (fr > hi_v) fc = hi_v;
    else                fc = fr;
  end
  assign res32 = fc[31:0];

  // ---- status
  always_comb begin
    sts.n_zero     = (ncnt == '0);
    sts.n_one      = (ncnt == NW'(1));
    sts.t_le       = (t_q <= rd_q.ktime);
    sts.t_ge       = (t_q >= rd_q.ktime);
    sts.pw_special = (e_q == EASE_LINEAR) || (e_q == '0) || (fq >= ONE) || (fq == '0);
    sts.x_norm     = (x_q[31:30] != 2'b00);
    sts.pexp_zero  = (pi_w > 10'(FRAC_BITS));
  end

  // ---- key store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && slot_ok) begin
      mem[IW'(key_index)] <= '{ktime: key_time, px: pos_x, py: pos_y, pz: pos_z,
                               tx: tgt_x, ty: tgt_y, tz: tgt_z,
                               fov: key_fov, ease: key_ease};
    end
    rd_q <= mem[idx];
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      done      <= 1'b0;
      lv        <= 1'b0;
    end else begin
      if (cfg_we) key_count <= cfg_wdata;
      done <= (cmd.op == OP_PUT) || (cmd.op == OP_EMPTY) || (cmd.op == OP_LFIN);
      lv   <= (cmd.op == OP_LERP);
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:   t_q <= sample_time;
      OP_IDX0:   idx <= '0;
      OP_IDXL:   idx <= last_idx;
      OP_IDX1:   idx <= IW'(1);
      OP_IDXINC: idx <= idx + IW'(1);
      OP_LATB: begin
        rec_b <= rd_q;
        idx   <= idx - IW'(1);
      end
      OP_DIVINIT: begin
        rec_a <= rd_q;
        rem   <= {1'b0, diff_w};
        span  <= span_w;
        fq    <= '0;
        e_q   <= 13'(({1'b0, rd_q.ease} + {1'b0, rec_b.ease}) >> 1);
      end
      OP_DIVSTEP: begin
        if (div_ge) begin
          rem <= (rem - {1'b0, span}) << 1;
          fq  <= {fq[FW-2:0], 1'b1};
        end else begin
          rem <= rem << 1;
          fq  <= {fq[FW-2:0], 1'b0};
        end
      end
      OP_POWINIT: begin
        x_q   <= 32'(fq) << (Q30 - FRAC_BITS);
        ip_q  <= '0;
        fracq <= '0;
        if (e_q == EASE_LINEAR)            pw <= fq;
        else if (e_q == '0 || fq >= ONE)   pw <= ONE;
        else                               pw <= '0;
      end
      OP_NORM: begin
        x_q  <= x_q << 1;
        ip_q <= ip_q + 5'd1;
      end
      OP_LOG: begin
        if (sq[61]) begin
          x_q           <= sq[62:31];
          fracq[bitsel] <= 1'b1;
        end else begin
          x_q <= sq[61:30];
        end
      end
      OP_MULE:    pr <= prod_e[47:8];
      OP_EXPINIT: begin
        y_q <= 31'd1 << Q30;
        pw  <= '0;
      end
      OP_EXP: begin
        if (pr[bitsel]) y_q <= ymul[60:30];
      end
      OP_EXPFIN: pw <= (ysh > 31'(ONE)) ? ONE : FW'(ysh);
      OP_SQ_PW, OP_SQ_S, OP_SQ_F: begin
        sx  <= sm_src;
        sx2 <= sqs[FRAC_BITS +: FW];
        if (cmd.op == OP_SQ_F) s2 <= sres;
      end
      OP_FIN: sres <= fprod[FRAC_BITS +: FW];
      default: ;
    endcase
    if (cmd.op == OP_LERP) begin
      lp  <= lprod;
      lch <= cmd.chan;
    end
  end

  // ---- result registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMPTY) begin
      track_empty <= 1'b1;
      out_pos_x   <= '0;
      out_pos_y   <= '0;
      out_pos_z   <= '0;
      out_tgt_x   <= '0;
      out_tgt_y   <= '0;
      out_tgt_z   <= '0;
      out_fov     <= FOV75;
    end else if (cmd.op == OP_PUT) begin
      track_empty <= 1'b0;
      out_pos_x   <= rd_q.px;
      out_pos_y   <= rd_q.py;
      out_pos_z   <= rd_q.pz;
      out_tgt_x   <= rd_q.tx;
      out_tgt_y   <= rd_q.ty;
      out_tgt_z   <= rd_q.tz;
      out_fov     <= rd_q.fov;
    end else if (lv) begin
      track_empty <= 1'b0;
      unique case (lch)
        CH_PX:   out_pos_x <= res32;
        CH_PY:   out_pos_y <= res32;
        CH_PZ:   out_pos_z <= res32;
        CH_TX:   out_tgt_x <= res32;
        CH_TY:   out_tgt_y <= res32;
        CH_TZ:   out_tgt_z <= res32;
        default: out_fov   <= res32[23:0];
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/keyframe_camera_sampler_unit.sv]
// ----------------------------------------------------------------------------
// keyframe_camera_sampler_unit
// Camera keyframe table with eased smoothstep sampling.
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  request   start && !busy         req_type, key fields, sample_time
//  result    done (one cycle)       track_empty, out_pos_*, out_tgt_*, out_fov
//  config    cfg_we                 cfg_wdata -> key_count
//
//  A keyframe write needs no further state; busy stays low.
//  An empty track strobes from the count check, a clamped sample from the
//  first or last key compare. An interpolated sample scans the keys, divides,
//  normalizes and runs the 30-step log and exp loops, which dominate.
//  Linear, zero or unit cases skip both loops.
//  Reset is synchronous; the key table is not cleared. done cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_camera_sampler_unit #(
  parameter int MAX_KEYS  = kcs_pkg::KCS_MAX_KEYS,
  parameter int FRAC_BITS = kcs_pkg::KCS_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               req_type,
  input  logic [3:0]         key_index,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tgt_x,
  input  logic signed [31:0] tgt_y,
  input  logic signed [31:0] tgt_z,
  input  logic [23:0]        key_fov,
  input  logic [12:0]        key_ease,
  input  logic signed [31:0] sample_time,
  output logic               done,
  output logic               track_empty,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_tgt_x,
  output logic signed [31:0] out_tgt_y,
  output logic signed [31:0] out_tgt_z,
  output logic [23:0]        out_fov
);
  import kcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kcs_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  kcs_dp #(
    .MAX_KEYS (MAX_KEYS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .key_index   (key_index),
    .key_time    (key_time),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tgt_x       (tgt_x),
    .tgt_y       (tgt_y),
    .tgt_z       (tgt_z),
    .key_fov     (key_fov),
    .key_ease    (key_ease),
    .sample_time (sample_time),
    .done        (done),
    .track_empty (track_empty),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .out_tgt_x   (out_tgt_x),
    .out_tgt_y   (out_tgt_y),
    .out_tgt_z   (out_tgt_z),
    .out_fov     (out_fov)
  );

endmodule

`default_nettype wire

[rtl/kcs_checker.sv]
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks of the keyframe camera sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               done,
  input logic               track_empty,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_pos_y,
  input logic signed [31:0] out_pos_z,
  input logic signed [31:0] out_tgt_x,
  input logic signed [31:0] out_tgt_y,
  input logic signed [31:0] out_tgt_z,
  input logic [23:0]        out_fov
);
  import kcs_pkg::*;

  localparam logic [63:0] FOV75_W = 64'd75 << KCS_FRAC_BITS;
  localparam logic [23:0] FOV75 = (FOV75_W > 64'(FOV_MAX)) ? FOV_MAX : FOV75_W[23:0];

  // a word only comes out of a sample in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a sample in progress");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy)
    else $error("accepted sample did not raise busy");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |=> !busy)
    else $error("keyframe write held the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (done && track_empty) |-> (out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0 &&
      out_tgt_x == 0 && out_tgt_y == 0 && out_tgt_z == 0 && out_fov == FOV75))
    else $error("empty track word not at defaults");

endmodule

bind keyframe_camera_sampler_unit kcs_checker u_kcs_checker (.*);

`default_nettype wire

[tb/sv/kcs_checker.sv]
// ----------------------------------------------------------------------------
// kcs_tb_checker
// Watches the request, config and result channels of the keyframe camera
// sampler, keeps its own copy of the key table and key count, predicts each
// sample word and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module kcs_tb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               req_type,
  input  logic [3:0]         key_index,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tgt_x,
  input  logic signed [31:0] tgt_y,
  input  logic signed [31:0] tgt_z,
  input  logic [23:0]        key_fov,
  input  logic [12:0]        key_ease,
  input  logic signed [31:0] sample_time,
  input  logic               done,
  input  logic               track_empty,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_pos_z,
  input  logic signed [31:0] out_tgt_x,
  input  logic signed [31:0] out_tgt_y,
  input  logic signed [31:0] out_tgt_z,
  input  logic [23:0]        out_fov,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcs_pkg::*;

  localparam longint unsigned ONE   = 64'd1 << KCS_FRAC_BITS;
  localparam longint unsigned ONE30 = 64'd1 << Q30;

  typedef struct packed {
    logic               empty;
    logic signed [31:0] px, py, pz, tx, ty, tz;
    logic [23:0]        fov;
  } view_t;

  key_t            track[KCS_MAX_KEYS];
  logic [4:0]      count_reg;
  view_t           view_q[$];
  longint unsigned half_root[31];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // f^(ease/256) in Q16, via -log2 in Q30 and a product of roots of one half
  function automatic longint unsigned ease_power(longint unsigned f, longint unsigned e);
    longint unsigned x, fracq, neg, p, pi, pf, y;
    int ip;
    if (e == EASE_LINEAR) return f;
    if (e == 0 || f >= ONE) return ONE;
    if (f == 0) return 0;
    x = f << (Q30 - KCS_FRAC_BITS);
    ip = 0;
    fracq = 0;
    while (x < ONE30) begin
      x = x << 1;
      ip++;
    end
    for (int k = 1; k <= Q30; k++) begin
      x = (x * x) >> Q30;
      if (x >= (ONE30 << 1)) begin
        x = x >> 1;
        fracq |= 64'd1 << (Q30 - k);
      end
    end
    neg = (longint'(ip) << Q30) - fracq;
    p   = (neg * e) >> 8;
    pi  = p >> Q30;
    if (pi > KCS_FRAC_BITS) return 0;
    pf = p & (ONE30 - 1);
    y  = ONE30;
    for (int k = 1; k <= Q30; k++) begin
      if ((pf >> (Q30 - k)) & 1) y = (y * half_root[k]) >> Q30;
    end
    y = y >> (pi + (Q30 - KCS_FRAC_BITS));
    return (y > ONE) ? ONE : y;
  endfunction

  function automatic longint unsigned smooth_q(longint unsigned x);
    longint unsigned x2;
    x2 = (x * x) >> KCS_FRAC_BITS;
    return (x2 * (3 * ONE - 2 * x)) >> KCS_FRAC_BITS;
  endfunction

  function automatic longint blend(longint a, longint b, longint unsigned s,
                                   longint lo, longint hi);
    longint p, q, r;
    p = (b - a) * longint'(s);
    if (p >= 0) q = p >>> KCS_FRAC_BITS;
    else q = -longint'((longint'(-p) + longint'(ONE - 1)) >>> KCS_FRAC_BITS);
    r = a + q;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic view_t key_view(int k);
    view_t v;
    v.empty = 1'b0;
    v.px = track[k].px;
    v.py = track[k].py;
    v.pz = track[k].pz;
    v.tx = track[k].tx;
    v.ty = track[k].ty;
    v.tz = track[k].tz;
    v.fov = track[k].fov;
    return v;
  endfunction

  function automatic view_t sample_track(logic signed [31:0] st);
    view_t v;
    int n, i, a, b;
    longint ts, ta, span, lo, hi;
    longint unsigned f, e, s2, sf;
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    n  = (count_reg > KCS_MAX_KEYS) ? KCS_MAX_KEYS : count_reg;
    ts = st;
    if (n == 0) begin
      v = '0;
      v.empty = 1'b1;
      v.fov = 24'(75 << KCS_FRAC_BITS);
      return v;
    end
    if (n == 1 || ts <= longint'(track[0].ktime)) return key_view(0);
    if (ts >= longint'(track[n-1].ktime)) return key_view(n - 1);
    for (i = 1; i < n; i++) begin
      if (ts <= longint'(track[i].ktime)) break;
    end
    if (i >= n) return key_view(n - 1);
    a = i - 1;
    b = i;
    ta = track[a].ktime;
    span = longint'(track[b].ktime) - ta;
    if (span > 0 && ts > ta) begin
      f = (unsigned'(ts - ta) << KCS_FRAC_BITS) / unsigned'(span);
      if (f > ONE) f = ONE;
    end else if (span > 0) begin
      f = 0;
    end else begin
      f = ONE;
    end
    e  = (64'(track[a].ease) + 64'(track[b].ease)) >> 1;
    s2 = smooth_q(smooth_q(ease_power(f, e)));
    sf = smooth_q(f);
    v.empty = 1'b0;
    v.px  = 32'(blend(track[a].px, track[b].px, s2, lo, hi));
    v.py  = 32'(blend(track[a].py, track[b].py, s2, lo, hi));
    v.pz  = 32'(blend(track[a].pz, track[b].pz, s2, lo, hi));
    v.tx  = 32'(blend(track[a].tx, track[b].tx, s2, lo, hi));
    v.ty  = 32'(blend(track[a].ty, track[b].ty, s2, lo, hi));
    v.tz  = 32'(blend(track[a].tz, track[b].tz, s2, lo, hi));
    v.fov = 24'(blend(longint'(track[a].fov), longint'(track[b].fov), sf, 0,
                      longint'(FOV_MAX)));
    return v;
  endfunction

  task automatic cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    longint unsigned c;
    fails = 0;
    pending = 0;
    c = ONE30 >> 1;
    half_root[0] = 0;
    for (int k = 1; k <= Q30; k++) begin
      c = int_sqrt(c << Q30);
      half_root[k] = c;
    end
    for (int k = 0; k < KCS_MAX_KEYS; k++) track[k] = '0;
    count_reg = '0;
  end

  always @(posedge clk) begin
    view_t w;
    if (rst) begin
      count_reg = '0;
      view_q.delete();
    end else begin
      if (done) begin
        if (view_q.size() == 0) begin
          $error("result word with no sample outstanding");
          fails++;
        end else begin
          w = view_q.pop_front();
          cmp_field("track_empty", w.empty, track_empty);
          cmp_field("out_pos_x", w.px, out_pos_x);
          cmp_field("out_pos_y", w.py, out_pos_y);
          cmp_field("out_pos_z", w.pz, out_pos_z);
          cmp_field("out_tgt_x", w.tx, out_tgt_x);
          cmp_field("out_tgt_y", w.ty, out_tgt_y);
          cmp_field("out_tgt_z", w.tz, out_tgt_z);
          cmp_field("out_fov", w.fov, out_fov);
        end
      end
      if (cfg_we) count_reg = cfg_wdata;
      if (start && !busy) begin
        if (req_type == 1'b0) begin
          track[key_index] = '{key_time, pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z,
                               key_fov, key_ease};
        end else begin
          view_q.push_back(sample_track(sample_time));
        end
      end
    end
    pending = view_q.size();
  end
endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives keyframe writes, key count settings and sample words into the
// keyframe camera sampler in random bursts; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kcs_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int WORD_GOAL  = 1850;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_wdata = '0;
  logic               req_type = 1'b0;
  logic [3:0]         key_index = '0;
  logic signed [31:0] key_time = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
  logic [23:0]        key_fov = '0;
  logic [12:0]        key_ease = '0;
  logic signed [31:0] sample_time = '0;
  logic               done;
  logic               track_empty;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_tgt_x, out_tgt_y, out_tgt_z;
  logic [23:0]        out_fov;
  int                 fails;
  int                 pending;

  int   idle_cycles = 0;
  int   burst_left = 0;
  int   n_writes = 0, n_samples = 0, n_settings = 0;
  int   cur_count = 0;
  logic signed [31:0] key_times[KCS_MAX_KEYS];

  keyframe_camera_sampler_unit u_top (.*);
  kcs_tb_checker u_chk (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic send_word(logic rq, logic [3:0] idx, key_t k, logic [31:0] st);
    req_type    <= rq;
    key_index   <= idx;
    key_time    <= k.ktime;
    pos_x       <= k.px;
    pos_y       <= k.py;
    pos_z       <= k.pz;
    tgt_x       <= k.tx;
    tgt_y       <= k.ty;
    tgt_z       <= k.tz;
    key_fov     <= k.fov;
    key_ease    <= k.ease;
    sample_time <= st;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rq) n_samples++;
    else n_writes++;
    pace();
  endtask

  // hold until every outstanding sample has strobed and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 5'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_count = v;
    n_settings++;
  endtask

  function automatic key_t rand_key();
    key_t k;
    int sel;
    k.ktime = $urandom;
    sel = $urandom_range(0, 7);
    k.px = (sel == 0) ? 32'h8000_0000 : (sel == 1) ? 32'h7FFF_FFFF : $urandom;
    k.py = (sel == 0) ? 32'h7FFF_FFFF : (sel == 1) ? 32'h8000_0000 : $urandom;
    k.pz = (sel == 2) ? 32'd0 : $urandom;
    k.tx = $urandom;
    k.ty = $urandom;
    k.tz = (sel == 3) ? 32'h8000_0000 : $urandom;
    case ($urandom_range(0, 5))
      0: k.fov = 24'd0;
      1: k.fov = 24'd11796480;
      2: k.fov = 24'($urandom);
      default: k.fov = 24'($urandom_range(0, 11796480));
    endcase
    case ($urandom_range(0, 9))
      0, 1: k.ease = EASE_LINEAR;
      2: k.ease = 13'd0;
      3: k.ease = 13'd4096;
      4: k.ease = 13'($urandom_range(0, 8191));
      5: k.ease = 13'($urandom_range(0, 4096));
      default: k.ease = 13'($urandom_range(64, 1024));
    endcase
    return k;
  endfunction

  // load all slots; mode picks the layout of the key times
  task automatic load_track(int mode);
    key_t   k;
    longint tt, step;
    tt = longint'($signed($urandom_range(0, 32'h7FFF_FFFF))) - 64'sd1073741824;
    for (int i = 0; i < KCS_MAX_KEYS; i++) begin
      k = rand_key();
      case (mode)
        0: begin
          step = (i == 0) ? 0 : $urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
                                                          : $urandom_range(1, 1 << 26);
          tt += step;
          k.ktime = 32'(tt);
        end
        1: begin
          tt += (i == 0) ? 0 : $urandom_range(0, 2);
          k.ktime = 32'(tt);
        end
        2: k.ktime = $urandom;
        default: k.ktime = 32'(-64'sd2147483648 + longint'(i) * 64'sd286331153);
      endcase
      key_times[i] = k.ktime;
      send_word(1'b0, 4'(i), k, $urandom);
    end
  endtask

  function automatic logic [31:0] pick_time();
    int     n, j;
    longint ta, span;
    n = (cur_count > KCS_MAX_KEYS) ? KCS_MAX_KEYS : cur_count;
    j = (n > 1) ? $urandom_range(0, n - 2) : 0;
    ta = key_times[j];
    span = longint'(key_times[j+1]) - ta;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return key_times[j];
      4: return 32'(ta + 1);
      5: return 32'(longint'(key_times[j+1]) - 1);
      default: begin
        if (span > 1) return 32'(ta + longint'({$urandom, $urandom} % span));
        return 32'(ta + $urandom_range(0, 3));
      end
    endcase
  endfunction

  task automatic run_samples(int n);
    for (int i = 0; i < n; i++) begin
      // now and then overwrite a slot mid-phase
      if ($urandom_range(0, 29) == 0) begin
        key_t k;
        int   s;
        k = rand_key();
        s = $urandom_range(0, KCS_MAX_KEYS - 1);
        key_times[s] = k.ktime;
        send_word(1'b0, 4'(s), k, $urandom);
      end
      send_word(1'b1, 4'($urandom), rand_key(), pick_time());
    end
  endtask

  initial begin
    int cnt;
    int layouts[6];
    int counts[6];
    layouts = '{3, 0, 0, 3, 1, 2};
    counts  = '{1, 2, 16, 31, 17, 16};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty track before anything is written
    set_count(0);
    send_word(1'b1, 4'hF, rand_key(), 32'h8000_0000);
    send_word(1'b1, 4'h0, rand_key(), 32'h7FFF_FFFF);
    send_word(1'b1, 4'h5, rand_key(), 32'd0);
    drain();
    load_track(3);

    for (int p = 0; p < 6; p++) begin
      set_count(counts[p]);
      if (p > 0 && layouts[p] != layouts[p-1]) begin
        drain();
        load_track(layouts[p]);
      end
      run_samples(4);
    end

    while (n_writes + n_samples < WORD_GOAL) begin
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = $urandom_range(17, 31);
        3: cnt = 16;
        default: cnt = $urandom_range(2, 16);
      endcase
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 9))
          0: load_track(1);
          1: load_track(2);
          2: load_track(3);
          default: load_track(0);
        endcase
      end
      set_count(cnt);
      run_samples($urandom_range(20, 60));
    end

    drain();
    repeat (300) @(posedge clk);
    $display("%0d keyframe writes and %0d samples over %0d key count settings",
             n_writes, n_samples, n_settings);
    $display("tracks: empty, single key, over-range counts, sorted, tied and unsorted times");
    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/kcs_pkg.sv
rtl/kcs_ctrl.sv
rtl/kcs_dp.sv
rtl/keyframe_camera_sampler_unit.sv
rtl/kcs_checker.sv
tb/sv/kcs_checker.sv
tb/sv/testbench.sv
